@@ rtl/rsog_pkg.sv @@
`timescale 1ns / 1ps

package rsog_pkg;

  // Default store geometry
  localparam int DEVICES_DEF     = 4;
  localparam int RANGE_CELLS_DEF = 16;
  localparam int ANGLE_CELLS_DEF = 16;

  // Stream payload widths
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SPAN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CELL_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CELL_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_CEILING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY_LEVEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSED          = 3'd6;

  // Register reset values
  localparam logic [7:0] RANGE_LIMIT_RST     = 8'd8;
  localparam logic [8:0] ANGLE_SPAN_RST      = 9'd160;
  localparam logic [7:0] RANGE_CELL_SIZE_RST = 8'd1;
  localparam logic [8:0] ANGLE_CELL_SIZE_RST = 9'd14;
  localparam logic [7:0] COUNT_CEILING_RST   = 8'd255;
  localparam logic [7:0] EXPIRY_LEVEL_RST    = 8'd128;

  // Request kinds
  localparam logic [1:0] REQ_OBSERVE = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_TICK     = 3'd2;
  localparam logic [2:0] ST_CLEARED  = 3'd3;
  localparam logic [2:0] ST_PAUSED   = 3'd4;

  // Velocity thresholds, 1/4096 m/s: still below 0.001 m/s, 0.15 m/s echo band
  localparam logic [15:0] VEL_STILL_MAX = 16'd4;
  localparam logic [15:0] VEL_ECHO_LO   = 16'd615;
  localparam logic [15:0] VEL_ECHO_HI   = 16'd622;

  // Shared divider: four lanes, nine quotient bits each
  localparam int DIV_W     = 9;
  localparam int DIV_LANES = 4;
  localparam int LANE_R    = 0;
  localparam int LANE_A    = 1;
  localparam int LANE_ROWS = 2;
  localparam int LANE_COLS = 3;

endpackage

@@ rtl/radar_static_occupancy_grid_core.sv @@
`timescale 1ns / 1ps

// Stationary-clutter occupancy grid: one 8-bit counter per range/angle cell per device, held
// in a single-port-read, single-port-write RAM of DEVICES*RANGE_CELLS*ANGLE_CELLS entries.
// One item is in flight at a time; a finished result waits in the output register while the
// next item is taken. An observation runs the four-lane restoring divider that finds the row,
// column and grid size, then map, address, RAM read and write-back; an observation that the
// mapping rejects ends after the map step. A decay tick walks the whole RAM with a pipelined
// read-modify-write; a device clear writes the device's RANGE_CELLS*ANGLE_CELLS entries;
// paused observations and ticks, unknown requests, and observations and clears for an absent
// device answer without touching the RAM. A result held back by the receiver stalls the next
// item once it is finished. After reset a clearing pass zeroes the RAM, during which no item
// is taken (configuration writes are).
module radar_static_occupancy_grid_core
  import rsog_pkg::*;
#(
  parameter int DEVICES     = DEVICES_DEF,
  parameter int RANGE_CELLS = RANGE_CELLS_DEF,
  parameter int ANGLE_CELLS = ANGLE_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // device_id[1:0], target_range[17:2], target_angle[33:18], target_velocity[49:34]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  s_axis_tlast,
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // suppress_target[0], row[4:1], column[8:5], cell_count[16:9]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int CELLS  = RANGE_CELLS * ANGLE_CELLS;
  localparam int DEPTH  = DEVICES * CELLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int STEP_W = $clog2(DIV_W);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_MAP  = 4'd3;
  localparam logic [3:0] S_ADDR = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_MOD  = 4'd6;
  localparam logic [3:0] S_TICK = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  // Configuration registers
  logic [7:0] range_limit;
  logic [8:0] angle_span;
  logic [7:0] range_cell_size;
  logic [8:0] angle_cell_size;
  logic [7:0] count_ceiling;
  logic [7:0] expiry_level;
  logic       paused;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit     <= RANGE_LIMIT_RST;
      angle_span      <= ANGLE_SPAN_RST;
      range_cell_size <= RANGE_CELL_SIZE_RST;
      angle_cell_size <= ANGLE_CELL_SIZE_RST;
      count_ceiling   <= COUNT_CEILING_RST;
      expiry_level    <= EXPIRY_LEVEL_RST;
      paused          <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LIMIT:     range_limit     <= cfg_wdata[7:0];
        REG_ANGLE_SPAN:      angle_span      <= cfg_wdata;
        REG_RANGE_CELL_SIZE: range_cell_size <= cfg_wdata[7:0];
        REG_ANGLE_CELL_SIZE: angle_cell_size <= cfg_wdata;
        REG_COUNT_CEILING:   count_ceiling   <= cfg_wdata[7:0];
        REG_EXPIRY_LEVEL:    expiry_level    <= cfg_wdata[7:0];
        REG_PAUSED:          paused          <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input field unpacking
  logic [1:0]  in_req;
  logic [1:0]  in_dev;
  logic [15:0] in_range;
  logic [15:0] in_angle;
  logic [15:0] in_vel;
  logic [15:0] in_amag;
  logic [15:0] in_vmag;
  logic        in_still;
  logic        in_dev_ok;
  logic        in_xfer;

  assign in_req   = s_axis_tuser;
  assign in_dev   = s_axis_tdata[1:0];
  assign in_range = s_axis_tdata[17:2];
  assign in_angle = s_axis_tdata[33:18];
  assign in_vel   = s_axis_tdata[49:34];

  // Magnitudes; the 0.15 m/s echo band counts as zero velocity
  assign in_amag   = in_angle[15] ? (~in_angle + 16'd1) : in_angle;
  assign in_vmag   = in_vel[15] ? (~in_vel + 16'd1) : in_vel;
  assign in_still  = (in_vmag <= VEL_STILL_MAX) ||
                     ((in_vmag >= VEL_ECHO_LO) && (in_vmag <= VEL_ECHO_HI));
  assign in_dev_ok = int'(in_dev) < DEVICES;

  // Registers
  logic [3:0]        state;
  logic [1:0]        dev;
  logic [15:0]       rng;
  logic [15:0]       amag;
  logic              aneg;
  logic              still;
  logic              last;
  logic [7:0]        row_idx;
  logic [7:0]        col_idx;
  logic [ADDR_W-1:0] obs_addr;
  logic [ADDR_W-1:0] walk_addr;
  logic [ADDR_W-1:0] walk_stop;
  logic [ADDR_W-1:0] pend_addr;
  logic              pend_valid;
  logic              tick_rd_done;
  logic [STEP_W-1:0] div_step;
  logic [2:0]        res_status;
  logic              res_supp;
  logic [3:0]        res_row;
  logic [3:0]        res_col;
  logic [7:0]        res_cnt;
  logic              out_valid;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Divider lanes: range row, angle column, grid rows, grid columns
  logic [DIV_W-1:0] div_num      [DIV_LANES];
  logic [DIV_W-1:0] div_rem      [DIV_LANES];
  logic [DIV_W-1:0] div_den      [DIV_LANES];
  logic [DIV_W-1:0] div_num_next [DIV_LANES];
  logic [DIV_W-1:0] div_rem_next [DIV_LANES];
  logic [DIV_W:0]   div_sh       [DIV_LANES];

  // One restoring step per lane
  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      div_sh[l] = {div_rem[l], div_num[l][DIV_W-1]};
      if (div_sh[l] >= {1'b0, div_den[l]}) begin
        div_rem_next[l] = DIV_W'(div_sh[l] - {1'b0, div_den[l]});
        div_num_next[l] = {div_num[l][DIV_W-2:0], 1'b1};
      end else begin
        div_rem_next[l] = div_sh[l][DIV_W-1:0];
        div_num_next[l] = {div_num[l][DIV_W-2:0], 1'b0};
      end
    end
  end

  // Cell mapping from the quotients
  logic [7:0] q_r;
  logic [8:0] q_a;
  logic [7:0] q_rows;
  logic [8:0] q_cols;
  logic [7:0] q_half;
  logic [9:0] a_m;
  logic       map_reject;

  assign q_r    = div_num[LANE_R][7:0];
  assign q_a    = div_num[LANE_A];
  assign q_rows = div_num[LANE_ROWS][7:0];
  assign q_cols = div_num[LANE_COLS];
  assign q_half = q_cols[8:1];
  assign a_m    = aneg ? (10'(q_half) - 10'(q_a)) : (10'(q_half) + 10'(q_a));

  assign map_reject = (range_cell_size == 8'd0) || (angle_cell_size == 9'd0) ||
                      (amag > {1'b0, angle_span[8:1], 7'd0}) ||
                      (rng > {range_limit, 8'd0}) ||
                      (aneg && (q_a > 9'(q_half))) ||
                      (a_m > 10'(q_cols)) || (q_r > q_rows) ||
                      (q_r == 8'd0) || (a_m == 10'd0) ||
                      (int'(q_r) > RANGE_CELLS) || (int'(a_m) > ANGLE_CELLS);

  // Memory ports
  logic [7:0]        mem [DEPTH];
  logic [7:0]        mem_rdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Counter update for an observation
  logic [7:0] cnt_new;
  logic       supp_new;

  always_comb begin
    cnt_new  = mem_rdata;
    supp_new = 1'b0;
    if (still) begin
      if (mem_rdata < count_ceiling) begin
        cnt_new = mem_rdata + 8'd1;
      end
      supp_new = cnt_new > expiry_level;
    end else if ((mem_rdata < expiry_level) && (mem_rdata != 8'd0)) begin
      cnt_new = mem_rdata - 8'd1;
    end
  end

  assign mem_raddr = (state == S_TICK) ? walk_addr : obs_addr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = walk_addr;
    mem_wdata = 8'd0;
    unique case (state)
      S_INIT, S_CLR: begin
        mem_we = 1'b1;
      end
      S_TICK: begin
        mem_we    = pend_valid;
        mem_waddr = pend_addr;
        mem_wdata = (mem_rdata == 8'd0) ? 8'd0 : (mem_rdata - 8'd1);
      end
      S_MOD: begin
        mem_we    = 1'b1;
        mem_waddr = obs_addr;
        mem_wdata = cnt_new;
      end
      default: ;
    endcase
  end

  // Sequencer
  logic out_free;
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      walk_addr    <= '0;
      walk_stop    <= ADDR_W'(DEPTH - 1);
      pend_valid   <= 1'b0;
      tick_rd_done <= 1'b0;
      div_step     <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (walk_addr == walk_stop) begin
            state <= S_IDLE;
          end else begin
            walk_addr <= walk_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            dev        <= in_dev;
            rng        <= in_range;
            amag       <= in_amag;
            aneg       <= in_angle[15];
            still      <= in_still;
            last       <= s_axis_tlast;
            res_status <= ST_REJECTED;
            res_supp   <= 1'b0;
            res_row    <= 4'd0;
            res_col    <= 4'd0;
            res_cnt    <= 8'd0;
            priority if (in_req == REQ_OBSERVE) begin
              if (paused) begin
                res_status <= ST_PAUSED;
                state      <= S_FIN;
              end else if (!in_dev_ok) begin
                state <= S_FIN;
              end else begin
                div_num[LANE_R]    <= {1'b0, in_range[15:8]};
                div_den[LANE_R]    <= {1'b0, range_cell_size};
                div_num[LANE_A]    <= in_amag[15:7];
                div_den[LANE_A]    <= angle_cell_size;
                div_num[LANE_ROWS] <= {1'b0, range_limit};
                div_den[LANE_ROWS] <= {1'b0, range_cell_size};
                div_num[LANE_COLS] <= angle_span;
                div_den[LANE_COLS] <= angle_cell_size;
                for (int l = 0; l < DIV_LANES; l++) begin
                  div_rem[l] <= '0;
                end
                div_step <= '0;
                state    <= S_DIV;
              end
            end else if (in_req == REQ_TICK) begin
              if (paused) begin
                res_status <= ST_PAUSED;
                state      <= S_FIN;
              end else begin
                res_status   <= ST_TICK;
                walk_addr    <= '0;
                walk_stop    <= ADDR_W'(DEPTH - 1);
                pend_valid   <= 1'b0;
                tick_rd_done <= 1'b0;
                state        <= S_TICK;
              end
            end else if (in_req == REQ_CLEAR) begin
              if (in_dev_ok) begin
                res_status <= ST_CLEARED;
                walk_addr  <= ADDR_W'(in_dev) * ADDR_W'(CELLS);
                walk_stop  <= ADDR_W'(in_dev) * ADDR_W'(CELLS) + ADDR_W'(CELLS - 1);
                state      <= S_CLR;
              end else begin
                state <= S_FIN;
              end
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_DIV: begin
          for (int l = 0; l < DIV_LANES; l++) begin
            div_num[l] <= div_num_next[l];
            div_rem[l] <= div_rem_next[l];
          end
          div_step <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(DIV_W - 1)) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          row_idx <= q_r - 8'd1;
          col_idx <= 8'(a_m - 10'd1);
          state   <= map_reject ? S_FIN : S_ADDR;
        end
        S_ADDR: begin
          obs_addr <= (ADDR_W'(dev) * ADDR_W'(RANGE_CELLS) + ADDR_W'(row_idx)) *
                      ADDR_W'(ANGLE_CELLS) + ADDR_W'(col_idx);
          state    <= S_RD;
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          res_status <= ST_UPDATED;
          res_supp   <= supp_new;
          res_row    <= row_idx[3:0];
          res_col    <= col_idx[3:0];
          res_cnt    <= cnt_new;
          state      <= S_FIN;
        end
        S_TICK: begin
          // read one entry per cycle, write it back decremented in the following cycle
          if (!tick_rd_done) begin
            pend_addr <= walk_addr;
            if (walk_addr == walk_stop) begin
              tick_rd_done <= 1'b1;
            end else begin
              walk_addr <= walk_addr + ADDR_W'(1);
            end
          end
          pend_valid <= !tick_rd_done;
          if (tick_rd_done && pend_valid) begin
            state <= S_FIN;
          end
        end
        S_CLR: begin
          if (walk_addr == walk_stop) begin
            state <= S_FIN;
          end else begin
            walk_addr <= walk_addr + ADDR_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {7'd0, res_cnt, res_col, res_row, res_supp};
      m_axis_tlast <= last;
    end
  end

  assign m_axis_tvalid = out_valid;

`ifndef NO_ASSERTIONS
  // one item at a time: a transfer closes the input until its result is made
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again straight after a transfer");

  // the grid is only written while an item is at work or during the clearing pass
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("grid written while idle");

  // results other than a cell update carry an empty payload
  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_status != ST_UPDATED) |->
      (res_cnt == 8'd0 && !res_supp && res_row == 4'd0 && res_col == 4'd0))
    else $error("payload set on a non-update result");

  // suppression only ever accompanies a cell update
  a_supp_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_supp) |-> (res_status == ST_UPDATED))
    else $error("suppression without cell update");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rsog_pkg::*;

  localparam int GRID_DEVICES = DEVICES_DEF;
  localparam int GRID_ROWS    = RANGE_CELLS_DEF;
  localparam int GRID_COLS    = ANGLE_CELLS_DEF;
  localparam int GRID_DEPTH   = GRID_DEVICES * GRID_ROWS * GRID_COLS;

  // req_type 3 is not a defined request
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 123;
  localparam int MAX_GAP         = 18;
  localparam int LONG_HOLD       = 250;
  localparam int DIRECTED_ROWS   = 34;
  localparam int MAX_PRINTED     = 40;

  typedef struct {
    logic [1:0]         kind;
    logic [1:0]         dev;
    logic [15:0]        rng;
    logic signed [15:0] azimuth;
    logic signed [15:0] speed;
    logic               last;
  } target_req_t;

  typedef struct {
    logic [2:0] status;
    logic       suppress;
    logic [3:0] row;
    logic [3:0] column;
    logic [7:0] level;
    logic       last;
  } grid_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [8:0]           cfg_val;
    target_req_t          item;
    bit                   typed;
    grid_result_t         want;
  } plan_step_t;

  localparam target_req_t  NO_ITEM  = '{REQ_OBSERVE, 2'd0, 16'd0, 16'sd0, 16'sd0, 1'b0};
  localparam grid_result_t BY_MODEL = '{ST_UPDATED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0};

  // Directed sequence, starting from the reset register values
  plan_step_t directed_plan [DIRECTED_ROWS] = '{
    // still target at 1.5 m, boresight: first hit of its cell
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_UPDATED, 1'b0, 4'd0, 4'd4, 8'd1, 1'b0}},
    // stillness edges and the 0.15 m/s echo band
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sd4, 1'b0},
      1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, -16'sd4, 1'b0},
      1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sd615, 1'b0},
      1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, -16'sd622, 1'b0},
      1'b0, BY_MODEL},
    // moving targets count down
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sd5, 1'b0},
      1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sh8000, 1'b0},
      1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sh7fff, 1'b0},
      1'b0, BY_MODEL},
    // range and angle extremes
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd1, 16'h0000, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_REJECTED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd2, 16'hffff, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_REJECTED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd3, 16'h0180, 16'sh8000, 16'sd0, 1'b0},
      1'b1, '{ST_REJECTED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd3, 16'h0180, 16'sh7fff, 16'sd0, 1'b0},
      1'b1, '{ST_REJECTED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd1, 16'h0180, -16'sd1, 16'sd0, 1'b0},
      1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd1, 16'h0180, -16'sd10240, 16'sd0, 1'b0},
      1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd2, 16'd2048, 16'sd10240, 16'sd0, 1'b0},
      1'b0, BY_MODEL},
    // unknown request, tick and clear
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_UNKNOWN, 2'd3, 16'h0180, 16'sd0, 16'sd0, 1'b1},
      1'b1, '{ST_REJECTED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b1}},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_TICK, 2'd3, 16'h0000, 16'sd0, 16'sd0, 1'b1},
      1'b1, '{ST_TICK, 1'b0, 4'd0, 4'd0, 8'd0, 1'b1}},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_CLEAR, 2'd1, 16'h0000, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_CLEARED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    // paused: observations and ticks frozen, a clear still works
    '{1'b1, REG_PAUSED, 9'd1, NO_ITEM, 1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_PAUSED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_TICK, 2'd0, 16'h0000, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_PAUSED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_CLEAR, 2'd2, 16'h0000, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_CLEARED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b1, REG_PAUSED, 9'd0, NO_ITEM, 1'b0, BY_MODEL},
    // count already at or above the ceiling is left alone
    '{1'b1, REG_COUNT_CEILING, 9'd0, NO_ITEM, 1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sd0, 1'b0},
      1'b0, BY_MODEL},
    '{1'b1, REG_COUNT_CEILING, 9'd255, NO_ITEM, 1'b0, BY_MODEL},
    // row beyond the stored grid
    '{1'b1, REG_RANGE_LIMIT, 9'd255, NO_ITEM, 1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'd5120, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_REJECTED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    // zero cell sizes reject everything
    '{1'b1, REG_RANGE_CELL_SIZE, 9'd0, NO_ITEM, 1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_REJECTED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b1, REG_RANGE_CELL_SIZE, 9'd1, NO_ITEM, 1'b0, BY_MODEL},
    '{1'b1, REG_ANGLE_CELL_SIZE, 9'd0, NO_ITEM, 1'b0, BY_MODEL},
    '{1'b0, REG_RANGE_LIMIT, 9'd0, '{REQ_OBSERVE, 2'd0, 16'h0180, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{ST_REJECTED, 1'b0, 4'd0, 4'd0, 8'd0, 1'b0}},
    '{1'b1, REG_ANGLE_CELL_SIZE, 9'd14, NO_ITEM, 1'b0, BY_MODEL}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  // Predictor state: grid copy and register shadows
  logic [7:0] clutter_grid [GRID_DEPTH];
  logic [7:0] cfg_range_limit = RANGE_LIMIT_RST;
  logic [8:0] cfg_angle_span  = ANGLE_SPAN_RST;
  logic [7:0] cfg_range_cell  = RANGE_CELL_SIZE_RST;
  logic [8:0] cfg_angle_cell  = ANGLE_CELL_SIZE_RST;
  logic [7:0] cfg_ceiling     = COUNT_CEILING_RST;
  logic [7:0] cfg_expiry      = EXPIRY_LEVEL_RST;
  logic       cfg_paused      = 1'b0;

  grid_result_t pending_grid_results [$];

  int mismatch_count  = 0;
  int results_seen    = 0;
  int observe_count   = 0;
  int updated_count   = 0;
  int suppress_count  = 0;
  int tick_count      = 0;
  int clear_count     = 0;
  int settings_count  = 0;
  bit sender_burst    = 1'b0;

  // Hot spot of the current phase, so counts climb past expiry
  logic [15:0]        hot_rng;
  logic signed [15:0] hot_azimuth;

  radar_static_occupancy_grid_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  function automatic int unsigned abs16(input logic signed [15:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  // Map a target onto its grid cell; 0 when the target is rejected
  function automatic bit locate_cell(input logic [15:0] rng16, input logic signed [15:0] az,
                                     output int unsigned rw, output int unsigned cl);
    int unsigned lim, span, rcs, acs, rows, cols, half, r, a, mag;
    rw   = 0;
    cl   = 0;
    lim  = cfg_range_limit;
    span = cfg_angle_span;
    rcs  = cfg_range_cell;
    acs  = cfg_angle_cell;
    if (rcs == 0 || acs == 0) return 1'b0;
    rows = lim / rcs;
    cols = span / acs;
    half = cols / 2;
    mag  = abs16(az);
    if (mag > (span / 2) * 128 || rng16 > lim * 256) return 1'b0;
    r = rng16 / (rcs * 256);
    a = mag / (acs * 128);
    if (az < 0) begin
      if (a > half) return 1'b0;
      a = half - a;
    end else begin
      a = half + a;
    end
    if (a > cols || r > rows) return 1'b0;
    if (r == 0 || a == 0) return 1'b0;
    r = r - 1;
    a = a - 1;
    if (r >= GRID_ROWS || a >= GRID_COLS) return 1'b0;
    rw = r;
    cl = a;
    return 1'b1;
  endfunction

  // Expected result of one request; updates the grid copy
  function automatic grid_result_t predict_grid_update(input target_req_t t);
    grid_result_t res;
    int unsigned  rw, cl, vmag, idx, cnt;
    res = BY_MODEL;
    res.status = ST_REJECTED;
    res.last = t.last;
    case (t.kind)
      REQ_OBSERVE: begin
        if (cfg_paused) begin
          res.status = ST_PAUSED;
        end else if (t.dev < GRID_DEVICES && locate_cell(t.rng, t.azimuth, rw, cl)) begin
          vmag = abs16(t.speed);
          if (vmag >= VEL_ECHO_LO && vmag <= VEL_ECHO_HI) vmag = 0;
          idx = (t.dev * GRID_ROWS + rw) * GRID_COLS + cl;
          cnt = clutter_grid[idx];
          if (vmag <= VEL_STILL_MAX) begin
            if (cnt < cfg_ceiling) cnt = cnt + 1;
            if (cnt > cfg_expiry) res.suppress = 1'b1;
          end else if (cnt < cfg_expiry && cnt > 0) begin
            cnt = cnt - 1;
          end
          clutter_grid[idx] = cnt[7:0];
          res.status = ST_UPDATED;
          res.row    = rw[3:0];
          res.column = cl[3:0];
          res.level  = cnt[7:0];
        end
      end
      REQ_TICK: begin
        if (cfg_paused) begin
          res.status = ST_PAUSED;
        end else begin
          for (int i = 0; i < GRID_DEPTH; i++)
            if (clutter_grid[i] != 8'd0) clutter_grid[i] = clutter_grid[i] - 8'd1;
          res.status = ST_TICK;
        end
      end
      REQ_CLEAR: begin
        if (t.dev < GRID_DEVICES) begin
          for (int i = 0; i < GRID_ROWS * GRID_COLS; i++)
            clutter_grid[t.dev * GRID_ROWS * GRID_COLS + i] = 8'd0;
          res.status = ST_CLEARED;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random request: mostly in-field targets, some noise, rare ticks, clears and unknown requests
  function automatic target_req_t make_target();
    target_req_t t;
    int unsigned pick, rmax, amax, mag;
    t = NO_ITEM;
    pick = $urandom_range(0, 99);
    if (pick < 2)      t.kind = REQ_TICK;
    else if (pick < 5) t.kind = REQ_CLEAR;
    else if (pick < 7) t.kind = REQ_UNKNOWN;
    else               t.kind = REQ_OBSERVE;
    t.dev  = 2'($urandom_range(0, 3));
    t.last = ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      t.rng     = hot_rng;
      t.azimuth = hot_azimuth;
    end else if (pick < 85) begin
      rmax = cfg_range_limit * 256 + 64;
      amax = (cfg_angle_span / 2) * 128 + 64;
      if (amax > 32767) amax = 32767;
      t.rng = 16'($urandom_range(0, rmax));
      mag   = $urandom_range(0, amax);
      t.azimuth = $urandom_range(0, 1) ? -16'(mag) : 16'(mag);
    end else begin
      t.rng     = 16'($urandom);
      t.azimuth = 16'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 45)      t.speed = 16'(int'($urandom_range(0, 8)) - 4);
    else if (pick < 55) t.speed = 16'($urandom_range(VEL_ECHO_LO, VEL_ECHO_HI));
    else if (pick < 60) t.speed = -16'($urandom_range(VEL_ECHO_LO - 4, VEL_ECHO_HI + 4));
    else                t.speed = 16'($urandom);
    return t;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTED)
      $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Called just after a falling edge; returns just after a falling edge, once the request has been accepted
  task automatic send_target(input target_req_t t, input bit typed, input grid_result_t want);
    grid_result_t predicted;
    grid_result_t expected;
    int           gap;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, t.speed, t.azimuth, t.rng, t.dev};
    s_axis_tuser  <= t.kind;
    s_axis_tlast  <= t.last;
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_grid_update(t);
    expected  = typed ? want : predicted;
    pending_grid_results.insert(pending_grid_results.size(), expected);
    case (t.kind)
      REQ_OBSERVE: observe_count++;
      REQ_TICK:    tick_count++;
      REQ_CLEAR:   clear_count++;
      default: ;
    endcase
    if (predicted.status == ST_UPDATED) updated_count++;
    if (predicted.suppress) suppress_count++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every result is back
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_grid_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Drives one register write, then drops the write enable before the next write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[8:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_RANGE_LIMIT:     cfg_range_limit = value[7:0];
      REG_ANGLE_SPAN:      cfg_angle_span  = value[8:0];
      REG_RANGE_CELL_SIZE: cfg_range_cell  = value[7:0];
      REG_ANGLE_CELL_SIZE: cfg_angle_cell  = value[8:0];
      REG_COUNT_CEILING:   cfg_ceiling     = value[7:0];
      REG_EXPIRY_LEVEL:    cfg_expiry      = value[7:0];
      REG_PAUSED:          cfg_paused      = value[0];
      default: ;
    endcase
  endtask

  // Result side: random back-pressure, two long hold-offs, field-by-field check
  initial begin
    grid_result_t got;
    grid_result_t want;
    int           gap;
    m_axis_tready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ((results_seen / 64) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.suppress = m_axis_tdata[0];
      got.row      = m_axis_tdata[4:1];
      got.column   = m_axis_tdata[8:5];
      got.level    = m_axis_tdata[16:9];
      got.status   = m_axis_tuser;
      got.last     = m_axis_tlast;
      if (pending_grid_results.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, 0);
      end else begin
        want = pending_grid_results.pop_front();
        if (got.status !== want.status)     report_mismatch("status", got.status, want.status);
        if (got.suppress !== want.suppress)
          report_mismatch("suppress_target", got.suppress, want.suppress);
        if (got.row !== want.row)           report_mismatch("row", got.row, want.row);
        if (got.column !== want.column)     report_mismatch("column", got.column, want.column);
        if (got.level !== want.level)       report_mismatch("cell_count", got.level, want.level);
        if (got.last !== want.last)         report_mismatch("last_out", got.last, want.last);
      end
      results_seen++;
      @(negedge clk);
      // hold results back long enough for the block to stall its input
      if (results_seen == 400 || results_seen == 1000) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
    end
  end

  // Request side
  initial begin
    int unsigned lim, span, rcs, acs, ceil, expiry, pause;
    target_req_t seed_target;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    for (int i = 0; i < GRID_DEPTH; i++) clutter_grid[i] = 8'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        settle_block();
        write_register(directed_plan[i].cfg_idx, directed_plan[i].cfg_val);
      end else begin
        send_target(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      case (phase)
        0: begin
          lim = RANGE_LIMIT_RST; span = ANGLE_SPAN_RST; rcs = RANGE_CELL_SIZE_RST;
          acs = ANGLE_CELL_SIZE_RST; ceil = COUNT_CEILING_RST; expiry = 20; pause = 0;
        end
        1: begin
          lim = 255; span = 360; rcs = 255; acs = 360; ceil = 0; expiry = 0; pause = 0;
        end
        2: begin
          lim = 1; span = 2; rcs = 1; acs = 1; ceil = 255; expiry = 255; pause = 0;
        end
        5: begin
          lim = 64; span = 90; rcs = 4; acs = 6; ceil = 100; expiry = 10; pause = 1;
        end
        default: begin
          lim  = $urandom_range(1, 255);
          rcs  = lim / $urandom_range(2, 20);
          if (rcs == 0) rcs = 1;
          span = $urandom_range(2, 360);
          acs  = span / $urandom_range(2, 20);
          if (acs == 0) acs = 1;
          ceil   = $urandom_range(0, 255);
          expiry = $urandom_range(0, 30);
          pause  = 0;
        end
      endcase
      write_register(REG_RANGE_LIMIT, lim);
      write_register(REG_ANGLE_SPAN, span);
      write_register(REG_RANGE_CELL_SIZE, rcs);
      write_register(REG_ANGLE_CELL_SIZE, acs);
      write_register(REG_COUNT_CEILING, ceil);
      write_register(REG_EXPIRY_LEVEL, expiry);
      write_register(REG_PAUSED, pause);
      settings_count++;
      sender_burst = (phase % 3 == 2);
      // pick this phase's spot from a random request
      hot_rng     = 16'd0;
      hot_azimuth = 16'sd0;
      seed_target = make_target();
      hot_rng     = seed_target.rng;
      hot_azimuth = seed_target.azimuth;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_target(make_target(), 1'b0, BY_MODEL);
    end

    // drain, then allow for any stray late result
    s_axis_tvalid <= 1'b0;
    while (pending_grid_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_grid_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_grid_results.size());
    $display("Run covered %0d requests: %0d observations (%0d cell updates, %0d suppressed),",
             results_seen, observe_count, updated_count, suppress_count);
    $display("  %0d decay ticks, %0d clears, %0d register settings, %0d mismatches",
             tick_count, clear_count, settings_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("Timeout with %0d results outstanding", pending_grid_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rsog_pkg.sv
rtl/radar_static_occupancy_grid_core.sv
tb/testbench.sv
